// ===== rtl/sha256_message_hasher_core_assert.svh =====
// Assertion macros shared by the hasher core.
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_0;
        logic [63:0] digest_1;
        logic [63:0] digest_2;
        logic [63:0] digest_3;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;  // write data byte at fill position, bump length
        logic       put_pad;    // write 0x80 at fill position, zero the rest
        logic       put_len;    // write the length into bytes 56..63
        logic       zero_all;   // zero the whole block (second pad block)
        logic       start;      // begin a compression
        logic       reset_msg;  // restore chain value, clear length
        logic [7:0] data;
    } t_sha_cmd;

    typedef struct packed {
        logic       busy;       // compression in progress
        logic [5:0] fill_pos;   // next byte position
    } t_sha_stat;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

endpackage
`default_nettype wire

// ===== rtl/sha256_datapath.sv =====
`default_nettype none
module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_sha_cmd  i_cmd,
    output t_sha_stat      o_stat,
    output logic [255:0]   o_chain
);

    // The schedule window doubles as the block buffer: bytes are written into
    // it big-endian, and the rounds shift it as they consume the block.
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [63:0] r_len;
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_fin;

    logic [5:0]  fill_pos;
    logic [31:0] t1, t2, s0, s1, w_cur, w_new;
    logic [31:0] big0, big1, chs, maj;
    logic [31:0] pad_w [16];

    assign fill_pos = r_len[8:3];

    always_comb begin
        w_cur = r_w[0];
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
             ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        big1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
               ^ {r_v[4][24:0], r_v[4][31:25]};
        chs  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
               ^ {r_v[0][21:0], r_v[0][31:22]};
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + big1 + chs + ROUND_K[r_round] + w_cur;
        t2 = big0 + maj;
    end

    // Pad byte at the fill position, zeros after it, earlier bytes kept.
    always_comb begin
        pad_w = r_w;
        for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
                if (6'(4 * i + b) == fill_pos) pad_w[i][8 * (3 - b) +: 8] = PAD_BYTE;
                else if (6'(4 * i + b) > fill_pos) pad_w[i][8 * (3 - b) +: 8] = 8'h00;
            end
        end
    end

    // Control: round counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Chain value and length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= H_INIT;
            r_len <= '0;
        end else if (i_cmd.reset_msg) begin
            r_h   <= H_INIT;
            r_len <= '0;
        end else begin
            if (r_fin) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.load_byte) begin
                r_len <= r_len + 64'd8;
            end
        end
    end

    // Block buffer and schedule window.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_w[fill_pos[5:2]][{~fill_pos[1:0], 3'b000} +: 8] <= i_cmd.data;
        end else if (i_cmd.put_pad) begin
            r_w <= pad_w;
        end else if (i_cmd.zero_all) begin
            for (int i = 0; i < 16; i++) r_w[i] <= '0;
        end else if (i_cmd.put_len) begin
            r_w[14] <= r_len[63:32];
            r_w[15] <= r_len[31:0];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v <= r_h;
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_stat.busy     = r_busy | r_fin;
    assign o_stat.fill_pos = fill_pos;
    assign o_chain = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4], r_h[5], r_h[6], r_h[7]};

endmodule
`default_nettype wire

// ===== rtl/sha256_ctrl.sv =====
`default_nettype none
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output logic           o_emit,
    input  wire t_sha_stat i_stat,
    output t_sha_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT  = 3'd1;  // compress after full block
    localparam logic [2:0] S_PAD   = 3'd2;
    localparam logic [2:0] S_WPAD  = 3'd3;  // compress first pad block
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_WLEN  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_oval, n_oval;
    logic       acc;

    // A waiting digest sits in the output register and does not hold the input.
    assign o_in_stall  = (r_state != S_IDLE);
    assign acc         = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_oval;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_oval  = r_oval & i_out_stall;
        o_cmd   = '0;
        o_cmd.data = i_in.data_byte;
        o_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_last = i_in.is_last;
                    if (i_in.has_byte) o_cmd.load_byte = 1'b1;
                    if (i_in.has_byte && i_stat.fill_pos == LAST_POS) begin
                        // The byte is written as the rounds start, before they read it.
                        o_cmd.start = 1'b1;
                        n_state = S_WAIT;
                    end else if (i_in.is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_WAIT: begin
                if (!i_stat.busy) begin
                    n_state = r_last ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.put_pad = 1'b1;
                if (i_stat.fill_pos >= LEN_POS) begin
                    o_cmd.start = 1'b1;
                    n_state = S_WPAD;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_WPAD: begin
                if (!i_stat.busy) begin
                    o_cmd.zero_all = 1'b1;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                o_cmd.start = 1'b1;
                n_state = S_WLEN;
            end
            S_WLEN: begin
                if (!i_stat.busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_oval) begin
                    o_emit = 1'b1;
                    o_cmd.reset_msg = 1'b1;
                    n_oval = 1'b1;
                    n_state = S_IDLE;
                    n_last = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_oval  <= n_oval;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_message_hasher_core.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid/o_in_stall   | t_in_item (has_byte, data_byte, is_last)
// out     | output    | o_out_valid/i_out_stall | t_out_item (digest_0..digest_3)
// A byte that does not complete a block is taken with no stall.
// A byte that completes a block stalls the input for the rounds, the fold and the done check.
// A last item stalls the input while the pad and length block is compressed and the digest is
// registered; a pad that spills into a second block, or a last byte that fills a block, adds a compression.
// Reset is synchronous, active low, and restores the initial chain value and zero length.
// A waiting digest does not stall the input; the next digest waits until it is taken.
`default_nettype none
`include "sha256_message_hasher_core_assert.svh"
module sha256_message_hasher_core
    import sha256_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    t_sha_cmd     cmd;
    t_sha_stat    stat;
    logic [255:0] chain;
    logic         emit;
    t_out_item    r_out;

    sha256_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in,
        .o_out_valid, .i_out_stall, .o_emit(emit), .i_stat(stat), .o_cmd(cmd)
    );

    sha256_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .o_chain(chain)
    );

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= chain;
    end
    assign o_out = r_out;

    `SHA_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, stat.busy, o_in_stall)
    `SHA_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, emit, o_out_valid)
    `SHA_ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, cmd.start, !stat.busy)

endmodule
`default_nettype wire

// ===== tb/sv/sha256_message_hasher_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sha256_message_hasher_core_tb;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    sha256_message_hasher_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // Predictor state.
    logic [31:0] hash_words [8];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;

    t_out_item digest_queue [$];
    int        error_count = 0;
    int        digests_seen = 0;
    int        bytes_sent = 0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    bit        sender_idle_ok = 0;
    bit        receiver_idle_ok = 0;
    bit        long_hold = 0;
    bit        hold_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++) begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        end
        for (int r = 0; r < 8; r++) v[r] = hash_words[r];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) hash_words[r] += v[r];
    endtask

    task automatic clear_message();
        for (int r = 0; r < 8; r++) hash_words[r] = H_INIT[r];
        msg_bits = '0;
    endtask

    task automatic predict_digest(t_in_item item);
        int pos;
        t_out_item d;
        if (item.has_byte) begin
            pos = int'(msg_bits[8:3]);
            msg_block[pos] = item.data_byte;
            msg_bits += 64'd8;
            if (pos == 63) compress_msg_block();
        end
        if (item.is_last) begin
            pos = int'(msg_bits[8:3]);
            msg_block[pos] = PAD_BYTE;
            pos++;
            if (pos > 56) begin
                for (int k = pos; k < 64; k++) msg_block[k] = 8'h00;
                compress_msg_block();
                pos = 0;
            end
            for (int k = pos; k < 56; k++) msg_block[k] = 8'h00;
            for (int k = 0; k < 8; k++) msg_block[56+k] = msg_bits[63-8*k -: 8];
            compress_msg_block();
            d.digest_0 = {hash_words[0], hash_words[1]};
            d.digest_1 = {hash_words[2], hash_words[3]};
            d.digest_2 = {hash_words[4], hash_words[5]};
            d.digest_3 = {hash_words[6], hash_words[7]};
            digest_queue.push_back(d);
            clear_message();
        end
    endtask

    // Called at a falling edge; valid is left high after the transaction so that
    // the next call can follow without a gap.
    task automatic send_item(t_in_item item);
        while (sender_idle_ok && ($urandom_range(99) < 35)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_digest(item);
        items_sent++;
        if (item.has_byte) bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, bit end_only);
        t_in_item item;
        for (int n = 0; n < len; n++) begin
            item.has_byte = 1'b1;
            item.data_byte = 8'($urandom);
            item.is_last = !end_only && (n == len - 1);
            // Sprinkle idle items, which the block should ignore.
            if ($urandom_range(19) == 0) send_item('{has_byte: 1'b0, data_byte: 8'($urandom),
                                                     is_last: 1'b0});
            send_item(item);
        end
        if (end_only || len == 0) begin
            send_item('{has_byte: 1'b0, data_byte: 8'($urandom), is_last: 1'b1});
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (digest_queue.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stall, with one long hold-off while the sender keeps going.
    always @(negedge i_clk) begin
        if (long_hold) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= receiver_idle_ok && ($urandom_range(99) < 35);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            digests_seen++;
            if (digest_queue.size() == 0) begin
                $error("digest with no transaction pending: %h", o_out);
                error_count++;
            end else begin
                t_out_item exp_d;
                exp_d = digest_queue.pop_front();
                if (o_out.digest_0 !== exp_d.digest_0) begin
                    $error("digest_0 expected %h actual %h", exp_d.digest_0, o_out.digest_0);
                    error_count++;
                end
                if (o_out.digest_1 !== exp_d.digest_1) begin
                    $error("digest_1 expected %h actual %h", exp_d.digest_1, o_out.digest_1);
                    error_count++;
                end
                if (o_out.digest_2 !== exp_d.digest_2) begin
                    $error("digest_2 expected %h actual %h", exp_d.digest_2, o_out.digest_2);
                    error_count++;
                end
                if (o_out.digest_3 !== exp_d.digest_3) begin
                    $error("digest_3 expected %h actual %h", exp_d.digest_3, o_out.digest_3);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    typedef struct {
        t_in_item  item;
        bit        check_fixed;
        t_out_item fixed_digest;
    } t_directed_row;

    t_directed_row directed_rows [$];

    initial begin
        t_in_item item;
        int len;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        clear_message();
        for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty message, then "abc" with known digests; then extremes checked by predictor.
        directed_rows.push_back('{'{1'b0, 8'h00, 1'b1}, 1'b1,
            '{64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
              64'h27ae41e4649b934c, 64'ha495991b7852b855}});
        directed_rows.push_back('{'{1'b1, 8'h61, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{1'b1, 8'h62, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{1'b1, 8'h63, 1'b1}, 1'b1,
            '{64'hba7816bf8f01cfea, 64'h414140de5dae2223,
              64'hb00361a396177a9c, 64'hb410ff61f20015ad}});
        directed_rows.push_back('{'{1'b0, 8'hff, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{1'b1, 8'hff, 1'b1}, 1'b0, '0});
        directed_rows.push_back('{'{1'b1, 8'h00, 1'b1}, 1'b0, '0});
        directed_rows.push_back('{'{1'b1, 8'hff, 1'b0}, 1'b0, '0});
        directed_rows.push_back('{'{1'b0, 8'hff, 1'b1}, 1'b0, '0});
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item);
            if (directed_rows[r].check_fixed &&
                digest_queue[$] !== directed_rows[r].fixed_digest) begin
                $error("digest expected %h predicted %h",
                       directed_rows[r].fixed_digest, digest_queue[$]);
                error_count++;
            end
        end
        // Lengths around the padding boundaries: 55, 56, 63, 64 bytes.
        send_message(55, 0);
        send_message(56, 0);
        send_message(63, 1);
        send_message(64, 0);
        wait_drained();

        // Random messages; the first stretch runs with no idling.
        while (items_sent < 1650) begin
            if (items_sent > 500) begin
                sender_idle_ok = 1;
                receiver_idle_ok = 1;
            end
            len = ($urandom_range(3) == 0) ? $urandom_range(130) : $urandom_range(12);
            if (items_sent > 900 && !hold_done) begin
                long_hold = 1;
                hold_done = 1;
                fork
                    begin
                        repeat (400) @(negedge i_clk);
                        long_hold = 0;
                    end
                join_none
            end
            send_message(len, $urandom_range(3) == 0);
            if ($urandom_range(9) == 0) wait_drained();
        end
        wait_drained();
        repeat (300) @(negedge i_clk);
        $display("Sent %0d transactions carrying %0d message bytes; %0d digests checked.",
                 items_sent, bytes_sent, digests_seen);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sha256_message_hasher_core.f =====
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_ctrl.sv
rtl/sha256_message_hasher_core.sv
tb/sv/sha256_message_hasher_core_tb.sv
